### design/sva_pkg.sv
// Shared types, constants and codes for the synth voice allocator.
// Used by sva_cell and synth_voice_allocator; depends on nothing.
package sva_pkg;

   localparam int VOICES_DEFAULT = 8;
   localparam logic [7:0] EMPTY_PITCH = 8'hFF;
   localparam logic [14:0] RENORM_LIMIT = 15'd30000;
   localparam logic [3:0] MAX_LEVEL = 4'd8;

   localparam logic OP_NOTE_ON = 1'b0;
   localparam logic OP_NOTE_OFF = 1'b1;

   localparam logic [1:0] GATE_NONE = 2'd0;
   localparam logic [1:0] GATE_TRIGGER = 2'd1;
   localparam logic [1:0] GATE_OFF = 2'd2;

   localparam logic [1:0] PRIO_LOW = 2'd1;
   localparam logic [1:0] PRIO_HIGH = 2'd2;

   localparam logic [2:0] REG_MONO_MODE = 3'd0;
   localparam logic [2:0] REG_MONO_PRIORITY = 3'd1;
   localparam logic [2:0] REG_LEGATO = 3'd2;
   localparam logic [2:0] REG_VOICE_COUNT = 3'd3;

   typedef struct packed {
      logic [7:0] pitch;
      logic [3:0] gate;
      logic [14:0] age;
   } slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_STEAL,
      ST_WRITE,
      ST_DONE
   } state_type;

   function automatic logic [14:0] renorm_age(input logic [14:0] a);
      renorm_age = (a >= RENORM_LIMIT) ? 15'(a - RENORM_LIMIT) : 15'd0;
   endfunction

endpackage

### design/synth_voice_allocator.sv
// Voice allocator top level: control sequencer, head unit and the ring of slot cells.
// Depends on sva_pkg and sva_cell.
// A note event makes up to three passes around the slot ring (scan, steal, write), then
// waits in the done state until the response register is free; the ring rotates one slot a
// cycle past the single head unit while a pass runs and holds otherwise. Events with pitch 0
// are taken with no result, as are note-offs for an absent pitch after the steal pass.
// After reset and after every write to a configuration register (indices 0 to 3) the table
// is cleared in one pass around the ring, during which no event is taken.
module synth_voice_allocator #(
   parameter int VOICES = sva_pkg::VOICES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_operation,
   input logic [6:0] req_pitch,
   input logic [3:0] req_level,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [2:0] rsp_voice,
   output logic [1:0] rsp_gate_action,
   output logic signed [4:0] rsp_trigger_level,
   output logic rsp_pitch_update,
   output logic [6:0] rsp_voice_pitch,
   input logic csr_valid,
   output logic csr_ready,
   input logic [2:0] csr_index,
   input logic [3:0] csr_data
);
   localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int NW = $clog2(VOICES + 1);

   sva_pkg::state_type state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic mode_ff, mode_in, legato_ff, legato_in;
   logic [1:0] prio_ff, prio_in;
   logic [3:0] vcount_ff, vcount_in;
   logic [14:0] counter_ff, counter_in;
   logic [NW-1:0] active_ff, active_in;
   logic mvalid_ff, mvalid_in;
   logic [IW-1:0] mslot_ff, mslot_in;
   logic op_ff, op_in;
   logic [6:0] pitch_ff, pitch_in;
   logic [3:0] lvl_ff, lvl_in;
   logic find_ok_ff, find_ok_in, free_ok_ff, free_ok_in;
   logic [IW-1:0] find_idx_ff, find_idx_in, free_idx_ff, free_idx_in;
   logic [14:0] free_age_ff, free_age_in;
   logic lo_ok_ff, lo_ok_in, hi_ok_ff, hi_ok_in;
   logic [IW-1:0] lo_idx_ff, lo_idx_in, hi_idx_ff, hi_idx_in;
   logic signed [8:0] lo_key_ff, lo_key_in, hi_key_ff, hi_key_in;
   logic steal_ok_ff, steal_ok_in;
   logic [IW-1:0] steal_idx_ff, steal_idx_in;
   logic [14:0] steal_age_ff, steal_age_in;
   logic [IW-1:0] target_ff, target_in;
   logic retrig_ff, retrig_in;
   logic mb_ok_ff, mb_ok_in;
   logic [IW-1:0] mb_idx_ff, mb_idx_in;
   logic [14:0] mb_key_ff, mb_key_in;
   logic [6:0] mb_pitch_ff, mb_pitch_in;
   logic rv_ff, rv_in;
   logic [2:0] rvoice_ff, rvoice_in;
   logic [1:0] ract_ff, ract_in;
   logic signed [4:0] rlvl_ff, rlvl_in;
   logic rupd_ff, rupd_in;
   logic [6:0] rpitch_ff, rpitch_in;

   sva_pkg::slot_type ring_q [VOICES];
   sva_pkg::slot_type ring_d [VOICES];
   sva_pkg::slot_type head_out;
   logic shift;
   logic [NW-1:0] n_cnt;

   genvar g;
   generate
      for (g = 0; g < VOICES; g++) begin : g_cell
         if (g == VOICES - 1) begin : g_last
            assign ring_d[g] = head_out;
         end else begin : g_mid
            assign ring_d[g] = ring_q[g+1];
         end
         sva_cell u_cell (.clock(clock), .shift(shift), .d(ring_d[g]), .q(ring_q[g]));
      end
   endgenerate

   always_comb begin
      if (vcount_ff == 4'd0) n_cnt = NW'(1);
      else if (32'(vcount_ff) > VOICES) n_cnt = NW'(VOICES);
      else n_cnt = NW'(vcount_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sva_pkg::ST_CLEAR;
         cnt_ff <= '0;
         mode_ff <= 1'b0;
         prio_ff <= 2'd0;
         legato_ff <= 1'b0;
         vcount_ff <= 4'd8;
         counter_ff <= '0;
         active_ff <= '0;
         mvalid_ff <= 1'b0;
         mslot_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         mode_ff <= mode_in;
         prio_ff <= prio_in;
         legato_ff <= legato_in;
         vcount_ff <= vcount_in;
         counter_ff <= counter_in;
         active_ff <= active_in;
         mvalid_ff <= mvalid_in;
         mslot_ff <= mslot_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      pitch_ff <= pitch_in;
      lvl_ff <= lvl_in;
      find_ok_ff <= find_ok_in;
      find_idx_ff <= find_idx_in;
      free_ok_ff <= free_ok_in;
      free_idx_ff <= free_idx_in;
      free_age_ff <= free_age_in;
      lo_ok_ff <= lo_ok_in;
      lo_idx_ff <= lo_idx_in;
      lo_key_ff <= lo_key_in;
      hi_ok_ff <= hi_ok_in;
      hi_idx_ff <= hi_idx_in;
      hi_key_ff <= hi_key_in;
      steal_ok_ff <= steal_ok_in;
      steal_idx_ff <= steal_idx_in;
      steal_age_ff <= steal_age_in;
      target_ff <= target_in;
      retrig_ff <= retrig_in;
      mb_ok_ff <= mb_ok_in;
      mb_idx_ff <= mb_idx_in;
      mb_key_ff <= mb_key_in;
      mb_pitch_ff <= mb_pitch_in;
      rvoice_ff <= rvoice_in;
      ract_ff <= ract_in;
      rlvl_ff <= rlvl_in;
      rupd_ff <= rupd_in;
      rpitch_ff <= rpitch_in;
   end

   always_comb begin
      sva_pkg::slot_type rec, eff;
      logic in_use, last, last_cell, renorm, clr_renorm, free, m_ok, changed;
      logic signed [8:0] key;
      logic [14:0] c1, c_clr, a_clr;
      logic [IW-1:0] m_idx;
      logic [6:0] m_pitch;

      rec = ring_q[0];
      in_use = NW'(cnt_ff) < n_cnt;
      last_cell = cnt_ff == IW'(VOICES - 1);
      last = last_cell;
      c1 = 15'(counter_ff + 15'd1);
      renorm = c1 > sva_pkg::RENORM_LIMIT;
      c_clr = 15'(counter_ff + 15'(n_cnt));
      clr_renorm = c_clr > sva_pkg::RENORM_LIMIT;
      a_clr = 15'(counter_ff + 15'(cnt_ff));
      free = !rv_ff || !rsp_stall;
      key = (rec.pitch == sva_pkg::EMPTY_PITCH) ? -9'sd1 : $signed({1'b0, rec.pitch});
      eff = rec;
      m_ok = 1'b0;
      m_idx = '0;
      m_pitch = '0;
      changed = 1'b0;

      state_in = state_ff;
      cnt_in = cnt_ff;
      mode_in = mode_ff;
      prio_in = prio_ff;
      legato_in = legato_ff;
      vcount_in = vcount_ff;
      counter_in = counter_ff;
      active_in = active_ff;
      mvalid_in = mvalid_ff;
      mslot_in = mslot_ff;
      op_in = op_ff;
      pitch_in = pitch_ff;
      lvl_in = lvl_ff;
      find_ok_in = find_ok_ff;
      find_idx_in = find_idx_ff;
      free_ok_in = free_ok_ff;
      free_idx_in = free_idx_ff;
      free_age_in = free_age_ff;
      lo_ok_in = lo_ok_ff;
      lo_idx_in = lo_idx_ff;
      lo_key_in = lo_key_ff;
      hi_ok_in = hi_ok_ff;
      hi_idx_in = hi_idx_ff;
      hi_key_in = hi_key_ff;
      steal_ok_in = steal_ok_ff;
      steal_idx_in = steal_idx_ff;
      steal_age_in = steal_age_ff;
      target_in = target_ff;
      retrig_in = retrig_ff;
      mb_ok_in = mb_ok_ff;
      mb_idx_in = mb_idx_ff;
      mb_key_in = mb_key_ff;
      mb_pitch_in = mb_pitch_ff;
      rv_in = rv_ff && rsp_stall;
      rvoice_in = rvoice_ff;
      ract_in = ract_ff;
      rlvl_in = rlvl_ff;
      rupd_in = rupd_ff;
      rpitch_in = rpitch_ff;
      head_out = rec;
      shift = 1'b0;
      req_stall = 1'b1;
      csr_ready = 1'b0;

      unique case (state_ff)
         sva_pkg::ST_CLEAR: begin
            shift = 1'b1;
            head_out.pitch = sva_pkg::EMPTY_PITCH;
            head_out.gate = 4'd0;
            if (in_use) begin
               head_out.age = clr_renorm ? sva_pkg::renorm_age(a_clr) : a_clr;
            end
            cnt_in = IW'(cnt_ff + 1'b1);
            if (last) begin
               cnt_in = '0;
               counter_in = clr_renorm ? 15'd0 : c_clr;
               active_in = '0;
               state_in = sva_pkg::ST_IDLE;
            end
         end
         sva_pkg::ST_IDLE: begin
            csr_ready = 1'b1;
            req_stall = csr_valid;
            cnt_in = '0;
            if (csr_valid) begin
               priority case (csr_index)
                  sva_pkg::REG_MONO_MODE: mode_in = csr_data[0];
                  sva_pkg::REG_MONO_PRIORITY: prio_in = csr_data[1:0];
                  sva_pkg::REG_LEGATO: legato_in = csr_data[0];
                  sva_pkg::REG_VOICE_COUNT: vcount_in = csr_data;
                  default: ;
               endcase
               if (csr_index <= sva_pkg::REG_VOICE_COUNT) state_in = sva_pkg::ST_CLEAR;
            end else if (req_valid && req_pitch != 7'd0) begin
               op_in = req_operation;
               pitch_in = req_pitch;
               lvl_in = (req_level > sva_pkg::MAX_LEVEL) ? sva_pkg::MAX_LEVEL : req_level;
               find_ok_in = 1'b0;
               free_ok_in = 1'b0;
               lo_ok_in = 1'b0;
               hi_ok_in = 1'b0;
               steal_ok_in = 1'b0;
               mb_ok_in = 1'b0;
               state_in = sva_pkg::ST_SCAN;
            end
         end
         sva_pkg::ST_SCAN: begin
            shift = 1'b1;
            if (in_use) begin
               if (rec.pitch == {1'b0, pitch_ff}) begin
                  find_ok_in = 1'b1;
                  find_idx_in = cnt_ff;
               end
               if (rec.gate == 4'd0 && (!free_ok_ff || rec.age < free_age_ff)) begin
                  free_ok_in = 1'b1;
                  free_idx_in = cnt_ff;
                  free_age_in = rec.age;
               end
               if (!lo_ok_ff || key < lo_key_ff) begin
                  lo_ok_in = 1'b1;
                  lo_idx_in = cnt_ff;
                  lo_key_in = key;
               end else if (!hi_ok_ff || key > hi_key_ff) begin
                  hi_ok_in = 1'b1;
                  hi_idx_in = cnt_ff;
                  hi_key_in = key;
               end
            end
            cnt_in = IW'(cnt_ff + 1'b1);
            if (last) begin
               cnt_in = '0;
               state_in = sva_pkg::ST_STEAL;
            end
         end
         sva_pkg::ST_STEAL: begin
            shift = 1'b1;
            if (in_use && !(lo_ok_ff && cnt_ff == lo_idx_ff)
                  && !(hi_ok_ff && cnt_ff == hi_idx_ff)
                  && (!steal_ok_ff || rec.age < steal_age_ff)) begin
               steal_ok_in = 1'b1;
               steal_idx_in = cnt_ff;
               steal_age_in = rec.age;
            end
            cnt_in = IW'(cnt_ff + 1'b1);
            if (last) begin
               cnt_in = '0;
               retrig_in = find_ok_ff;
               target_in = find_idx_ff;
               state_in = sva_pkg::ST_IDLE;
               if (find_ok_ff) begin
                  state_in = sva_pkg::ST_WRITE;
               end else if (op_ff == sva_pkg::OP_NOTE_ON) begin
                  if (active_ff != n_cnt) begin
                     target_in = free_idx_ff;
                     if (free_ok_ff) state_in = sva_pkg::ST_WRITE;
                  end else if (steal_ok_in) begin
                     target_in = steal_idx_in;
                     state_in = sva_pkg::ST_WRITE;
                     if (active_ff != '0) active_in = NW'(active_ff - 1'b1);
                  end
               end
            end
         end
         sva_pkg::ST_WRITE: begin
            shift = 1'b1;
            if (cnt_ff == target_ff) begin
               if (op_ff == sva_pkg::OP_NOTE_ON) begin
                  eff.pitch = {1'b0, pitch_ff};
                  eff.gate = lvl_ff;
               end else begin
                  eff.gate = 4'd0;
               end
               eff.age = c1;
            end
            if (in_use && eff.gate != 4'd0) begin
               priority case (prio_ff)
                  sva_pkg::PRIO_LOW: begin
                     if (!mb_ok_ff || 15'(eff.pitch) < mb_key_ff) begin
                        mb_ok_in = 1'b1;
                        mb_idx_in = cnt_ff;
                        mb_key_in = 15'(eff.pitch);
                        mb_pitch_in = eff.pitch[6:0];
                     end
                  end
                  sva_pkg::PRIO_HIGH: begin
                     if (!mb_ok_ff || 15'(eff.pitch) > mb_key_ff) begin
                        mb_ok_in = 1'b1;
                        mb_idx_in = cnt_ff;
                        mb_key_in = 15'(eff.pitch);
                        mb_pitch_in = eff.pitch[6:0];
                     end
                  end
                  default: begin
                     if (!mb_ok_ff || eff.age > mb_key_ff) begin
                        mb_ok_in = 1'b1;
                        mb_idx_in = cnt_ff;
                        mb_key_in = eff.age;
                        mb_pitch_in = eff.pitch[6:0];
                     end
                  end
               endcase
            end
            head_out = eff;
            if (in_use && renorm) head_out.age = sva_pkg::renorm_age(eff.age);
            cnt_in = IW'(cnt_ff + 1'b1);
            if (last) begin
               cnt_in = '0;
               counter_in = renorm ? 15'd0 : c1;
               state_in = sva_pkg::ST_DONE;
            end
         end
         sva_pkg::ST_DONE: begin
            if (free) begin
               rv_in = 1'b1;
               rvoice_in = 3'd0;
               ract_in = sva_pkg::GATE_NONE;
               rlvl_in = 5'sd0;
               rupd_in = 1'b0;
               rpitch_in = 7'd0;
               state_in = sva_pkg::ST_IDLE;
               if (op_ff == sva_pkg::OP_NOTE_ON) begin
                  if (!mode_ff) begin
                     rvoice_in = 3'(target_ff);
                     ract_in = sva_pkg::GATE_TRIGGER;
                     rlvl_in = $signed({1'b0, lvl_ff});
                     rupd_in = !retrig_ff;
                     rpitch_in = retrig_ff ? 7'd0 : pitch_ff;
                  end else begin
                     if (prio_ff == sva_pkg::PRIO_LOW || prio_ff == sva_pkg::PRIO_HIGH) begin
                        m_ok = mb_ok_ff;
                        m_idx = mb_idx_ff;
                        m_pitch = mb_pitch_ff;
                     end else begin
                        m_ok = 1'b1;
                        m_idx = target_ff;
                        m_pitch = pitch_ff;
                     end
                     changed = (m_ok != mvalid_ff) || (m_ok && m_idx != mslot_ff);
                     mvalid_in = m_ok;
                     mslot_in = m_ok ? m_idx : '0;
                     if (changed || active_ff == '0) begin
                        ract_in = sva_pkg::GATE_TRIGGER;
                        rlvl_in = (legato_ff && active_ff != '0)
                              ? -$signed({1'b0, lvl_ff}) : $signed({1'b0, lvl_ff});
                        rupd_in = changed && m_ok;
                        rpitch_in = (changed && m_ok) ? m_pitch : 7'd0;
                     end
                  end
                  if (active_ff < n_cnt) active_in = NW'(active_ff + 1'b1);
               end else begin
                  if (!mode_ff) begin
                     rvoice_in = 3'(target_ff);
                     ract_in = sva_pkg::GATE_OFF;
                  end else if (active_ff == NW'(1)) begin
                     ract_in = sva_pkg::GATE_OFF;
                  end else if (mvalid_ff && target_ff == mslot_ff) begin
                     mvalid_in = mb_ok_ff;
                     mslot_in = mb_ok_ff ? mb_idx_ff : '0;
                     if (mb_ok_ff) begin
                        ract_in = sva_pkg::GATE_TRIGGER;
                        rlvl_in = $signed({1'b0, lvl_ff});
                        rupd_in = 1'b1;
                        rpitch_in = mb_pitch_ff;
                     end else begin
                        ract_in = sva_pkg::GATE_OFF;
                     end
                  end
                  if (active_ff != '0) active_in = NW'(active_ff - 1'b1);
               end
            end
         end
         default: state_in = sva_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_voice = rvoice_ff;
   assign rsp_gate_action = ract_ff;
   assign rsp_trigger_level = rlvl_ff;
   assign rsp_pitch_update = rupd_ff;
   assign rsp_voice_pitch = rpitch_ff;

   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != sva_pkg::ST_CLEAR |-> active_ff <= n_cnt)
      else $error("active count exceeds slots in use");
   a_counter_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == sva_pkg::ST_IDLE |-> counter_ff <= sva_pkg::RENORM_LIMIT)
      else $error("age counter above renormalization limit while idle");
   a_target_in_use: assert property (@(posedge clock) disable iff (reset)
      state_ff == sva_pkg::ST_WRITE |-> NW'(target_ff) < n_cnt)
      else $error("write pass targets a slot that is not in use");
endmodule

### design/sva_cell.sv
// One voice slot record of the rotating slot ring.
// Depends on sva_pkg for the slot record type.
module sva_cell (
   input logic clock,
   input logic shift,
   input sva_pkg::slot_type d,
   output sva_pkg::slot_type q
);
   sva_pkg::slot_type rec_ff;
   sva_pkg::slot_type rec_in;

   always_comb begin
      rec_in = shift ? d : rec_ff;
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign q = rec_ff;
endmodule
